/* design/ordered_array_table_engine_unit_macros.svh */
// Assertion macros used by the port-level checker of the ordered array table engine.
`ifndef ORDERED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OATE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oate check failed");

// The consequent must hold in the cycle after the antecedent.
`define OATE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oate check failed");

`endif

/* design/oate_pkg.sv */
// Package with the field widths, codes and control types of the ordered array table engine.
package oate_pkg;

   localparam int unsigned OpW     = 3;
   localparam int unsigned ValueW  = 32;
   localparam int unsigned PosW    = 7;
   localparam int unsigned StatusW = 3;
   localparam int unsigned IndexW  = 6;
   localparam int unsigned CountW  = 7;
   localparam int unsigned DpCodeW = 3;

   // Operation codes of an input item.
   localparam logic [OpW-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OpW-1:0] OP_INSERT = 3'd1;
   localparam logic [OpW-1:0] OP_DELETE = 3'd2;
   localparam logic [OpW-1:0] OP_SEARCH = 3'd3;
   localparam logic [OpW-1:0] OP_SORT   = 3'd4;
   localparam logic [OpW-1:0] OP_DUMP   = 3'd5;

   // Result status codes.
   localparam logic [StatusW-1:0] ST_OK       = 3'd0;
   localparam logic [StatusW-1:0] ST_BADPOS   = 3'd1;
   localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
   localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [StatusW-1:0] ST_EMPTY    = 3'd4;

   // Datapath commands.
   localparam logic [DpCodeW-1:0] DP_NOP      = 3'd0;
   localparam logic [DpCodeW-1:0] DP_CLEAR    = 3'd1;
   localparam logic [DpCodeW-1:0] DP_INSERT   = 3'd2;
   localparam logic [DpCodeW-1:0] DP_DELETE   = 3'd3;
   localparam logic [DpCodeW-1:0] DP_LOAD_KEY = 3'd4;
   localparam logic [DpCodeW-1:0] DP_ROTATE   = 3'd5;
   localparam logic [DpCodeW-1:0] DP_SORT_EVN = 3'd6;
   localparam logic [DpCodeW-1:0] DP_SORT_ODD = 3'd7;

   typedef struct packed {
      logic [DpCodeW-1:0] code;
      logic [PosW-1:0]    position;
      logic [ValueW-1:0]  value;
   } dp_cmd_type;

   typedef struct packed {
      logic [CountW-1:0] count;
      logic [ValueW-1:0] head;
      logic              head_match;
   } dp_stat_type;

endpackage

/* design/oate_req_if.sv */
// Request channel of the ordered array table engine.
interface oate_req_if;
   logic                               valid;
   logic                               ready;
   logic [oate_pkg::OpW-1:0]           op;
   logic signed [oate_pkg::ValueW-1:0] item_value;
   logic [oate_pkg::PosW-1:0]          position;

   modport source(output valid, output op, output item_value, output position, input ready);
   modport sink(input valid, input op, input item_value, input position, output ready);
endinterface

/* design/oate_rsp_if.sv */
// Response channel of the ordered array table engine.
interface oate_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [oate_pkg::StatusW-1:0]       status;
   logic [oate_pkg::IndexW-1:0]        found_index;
   logic signed [oate_pkg::ValueW-1:0] entry_value;
   logic [oate_pkg::CountW-1:0]        count_now;
   logic                               last;

   modport source(output valid, output status, output found_index, output entry_value,
                  output count_now, output last, input ready);
   modport sink(input valid, input status, input found_index, input entry_value,
                input count_now, input last, output ready);
endinterface

/* design/oate_dpath.sv */
// Datapath of the ordered array table engine: the row of entry cells, the count and the key.
module oate_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  oate_pkg::dp_cmd_type cmd,
   output oate_pkg::dp_stat_type stat
);

   logic [oate_pkg::ValueW-1:0] cells_ff [DEPTH];
   logic [oate_pkg::ValueW-1:0] cells_in [DEPTH];
   logic [oate_pkg::ValueW-1:0] key_ff, key_in;
   logic [oate_pkg::CountW-1:0] count_ff, count_in;

   always_comb begin
      cells_in = cells_ff;
      key_in   = key_ff;
      count_in = count_ff;
      case (cmd.code)
         oate_pkg::DP_CLEAR: begin
            count_in = '0;
         end
         oate_pkg::DP_INSERT: begin
            // Every cell above the position takes its lower neighbor.
            for (int i = 1; i < DEPTH; i++) begin
               if (oate_pkg::CountW'(i) > cmd.position) begin
                  cells_in[i] = cells_ff[i-1];
               end
            end
            for (int i = 0; i < DEPTH; i++) begin
               if (oate_pkg::CountW'(i) == cmd.position) begin
                  cells_in[i] = cmd.value;
               end
            end
            count_in = count_ff + oate_pkg::CountW'(1);
         end
         oate_pkg::DP_DELETE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (oate_pkg::CountW'(i) >= cmd.position) begin
                  cells_in[i] = cells_ff[i+1];
               end
            end
            count_in = count_ff - oate_pkg::CountW'(1);
         end
         oate_pkg::DP_LOAD_KEY: begin
            key_in = cmd.value;
         end
         oate_pkg::DP_ROTATE: begin
            // A full turn of DEPTH rotations brings the row back to its order.
            for (int i = 0; i < DEPTH - 1; i++) begin
               cells_in[i] = cells_ff[i+1];
            end
            cells_in[DEPTH-1] = cells_ff[0];
         end
         oate_pkg::DP_SORT_EVN, oate_pkg::DP_SORT_ODD: begin
            // One phase of odd-even transposition; only pairs inside the count take part.
            for (int a = 0; a < DEPTH - 1; a++) begin
               if (((a % 2) == 1) == (cmd.code == oate_pkg::DP_SORT_ODD) &&
                   oate_pkg::CountW'(a + 1) < count_ff &&
                   $signed(cells_ff[a]) > $signed(cells_ff[a+1])) begin
                  cells_in[a]   = cells_ff[a+1];
                  cells_in[a+1] = cells_ff[a];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count      = count_ff;
   assign stat.head       = cells_ff[0];
   assign stat.head_match = (cells_ff[0] == key_ff);

endmodule

/* design/oate_ctrl.sv */
// Controller of the ordered array table engine: operation sequencing and the result register.
module oate_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [oate_pkg::OpW-1:0]           req_op,
   input  logic [oate_pkg::ValueW-1:0]        req_item_value,
   input  logic [oate_pkg::PosW-1:0]          req_position,
   output oate_pkg::dp_cmd_type               cmd,
   input  oate_pkg::dp_stat_type              stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [oate_pkg::StatusW-1:0]       rsp_status,
   output logic [oate_pkg::IndexW-1:0]        rsp_found_index,
   output logic [oate_pkg::ValueW-1:0]        rsp_entry_value,
   output logic [oate_pkg::CountW-1:0]        rsp_count_now,
   output logic                               rsp_last
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IW-1:0] LastStep = IW'(DEPTH - 1);
   localparam logic [oate_pkg::CountW-1:0] DepthCount = oate_pkg::CountW'(DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_SORT   = 3'd2;
   localparam logic [2:0] S_DUMP   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [IW-1:0]                 step_ff, step_in;
   logic                          hit_ff, hit_in;
   logic [oate_pkg::IndexW-1:0]   hit_idx_ff, hit_idx_in;
   logic [oate_pkg::StatusW-1:0]  fin_status_ff, fin_status_in;

   logic                          out_valid_ff, out_valid_in;
   logic [oate_pkg::StatusW-1:0]  out_status_ff, out_status_in;
   logic [oate_pkg::IndexW-1:0]   out_index_ff, out_index_in;
   logic [oate_pkg::ValueW-1:0]   out_value_ff, out_value_in;
   logic [oate_pkg::CountW-1:0]   out_count_ff, out_count_in;
   logic                          out_last_ff, out_last_in;

   logic                          slot_free;
   logic                          accept;
   logic                          step_last;
   logic                          step_live;
   logic                          hit_now;
   logic [oate_pkg::CountW-1:0]   step_wide;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign step_last = (step_ff == LastStep);
   assign step_wide = oate_pkg::CountW'(step_ff);
   assign step_live = (step_wide < stat.count);
   assign hit_now   = step_live && !hit_ff && stat.head_match;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      fin_status_in = fin_status_ff;
      cmd.code      = oate_pkg::DP_NOP;
      cmd.position  = req_position;
      cmd.value     = req_item_value;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Single-result defaults; each arm adjusts what differs.
               out_index_in = '0;
               out_value_in = '0;
               out_last_in  = 1'b1;
               out_count_in = stat.count;
               step_in      = '0;
               case (req_op)
                  oate_pkg::OP_CLEAR: begin
                     cmd.code      = oate_pkg::DP_CLEAR;
                     out_valid_in  = 1'b1;
                     out_status_in = oate_pkg::ST_OK;
                     out_count_in  = '0;
                  end
                  oate_pkg::OP_INSERT: begin
                     out_valid_in = 1'b1;
                     if (req_position > stat.count) begin
                        out_status_in = oate_pkg::ST_BADPOS;
                     end else if (stat.count >= DepthCount) begin
                        out_status_in = oate_pkg::ST_FULL;
                     end else begin
                        cmd.code      = oate_pkg::DP_INSERT;
                        out_status_in = oate_pkg::ST_OK;
                        out_count_in  = stat.count + oate_pkg::CountW'(1);
                     end
                  end
                  oate_pkg::OP_DELETE: begin
                     out_valid_in = 1'b1;
                     if (req_position >= stat.count) begin
                        out_status_in = oate_pkg::ST_BADPOS;
                     end else begin
                        cmd.code      = oate_pkg::DP_DELETE;
                        out_status_in = oate_pkg::ST_OK;
                        out_count_in  = stat.count - oate_pkg::CountW'(1);
                     end
                  end
                  oate_pkg::OP_SEARCH: begin
                     cmd.code   = oate_pkg::DP_LOAD_KEY;
                     hit_in     = 1'b0;
                     hit_idx_in = '0;
                     state_in   = S_SEARCH;
                  end
                  oate_pkg::OP_SORT: begin
                     state_in = S_SORT;
                  end
                  oate_pkg::OP_DUMP: begin
                     if (stat.count == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = oate_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // The entry at the head in step k is the original entry k.
            cmd.code = oate_pkg::DP_ROTATE;
            step_in  = step_ff + IW'(1);
            if (hit_now) begin
               hit_in     = 1'b1;
               hit_idx_in = oate_pkg::IndexW'(step_ff);
            end
            if (step_last) begin
               fin_status_in = (hit_ff || hit_now) ? oate_pkg::ST_OK : oate_pkg::ST_NOTFOUND;
               state_in      = S_FINISH;
            end
         end
         S_SORT: begin
            cmd.code = step_ff[0] ? oate_pkg::DP_SORT_ODD : oate_pkg::DP_SORT_EVN;
            step_in  = step_ff + IW'(1);
            if (step_last) begin
               fin_status_in = oate_pkg::ST_OK;
               hit_idx_in    = '0;
               state_in      = S_FINISH;
            end
         end
         S_DUMP: begin
            // Live steps wait for room in the result register; the rest only rotate.
            if (!step_live || slot_free) begin
               cmd.code = oate_pkg::DP_ROTATE;
               step_in  = step_ff + IW'(1);
               if (step_live) begin
                  out_valid_in  = 1'b1;
                  out_status_in = oate_pkg::ST_OK;
                  out_index_in  = oate_pkg::IndexW'(step_ff);
                  out_value_in  = stat.head;
                  out_count_in  = stat.count;
                  out_last_in   = ((step_wide + oate_pkg::CountW'(1)) == stat.count);
               end
               if (step_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = fin_status_ff;
               out_index_in  = hit_idx_ff;
               out_value_in  = '0;
               out_count_in  = stat.count;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      fin_status_ff <= fin_status_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_index = out_index_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_count_now   = out_count_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* design/ordered_array_table_engine_unit.sv */
// Ordered array table engine: keeps up to DEPTH signed 32-bit entries in a row of cells and
// applies one operation per request item. Clear, insert, delete and a dump of an empty array
// finish in the cycle they are accepted and post one result item from the output register on
// the next cycle. Search and sort post one result item from a finish state: search turns the
// cell row once around while comparing the head cell with the key, and sort runs DEPTH phases
// of odd-even transposition over neighboring cells. Dump also turns the row once around,
// holding while the response side stalls, and otherwise emits one entry per cycle with the
// last entry marked. A new request item is taken whenever the engine is idle and the output
// register is empty or being read in that cycle; a result that waits unread holds off the
// next item. Op codes six and seven are taken and ignored.
module ordered_array_table_engine_unit #(
   parameter int DEPTH = 64
) (
   input logic         clock,
   input logic         reset,
   oate_req_if.sink    req_chan,
   oate_rsp_if.source  rsp_chan
);

   oate_pkg::dp_cmd_type  dp_cmd;
   oate_pkg::dp_stat_type dp_stat;

   oate_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_op          (req_chan.op),
      .req_item_value  (req_chan.item_value),
      .req_position    (req_chan.position),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_found_index (rsp_chan.found_index),
      .rsp_entry_value (rsp_chan.entry_value),
      .rsp_count_now   (rsp_chan.count_now),
      .rsp_last        (rsp_chan.last)
   );

   oate_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (dp_cmd),
      .stat  (dp_stat)
   );

endmodule

/* design/oate_checker.sv */
// Port-level checker for the ordered array table engine, bound to the top level.
`include "ordered_array_table_engine_unit_macros.svh"

module oate_checker #(
   parameter int DEPTH = 64
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [oate_pkg::StatusW-1:0]       rsp_status,
   input logic [oate_pkg::IndexW-1:0]        rsp_found_index,
   input logic [oate_pkg::CountW-1:0]        rsp_count_now,
   input logic                               rsp_last
);

   localparam logic [oate_pkg::CountW-1:0] DepthCount = oate_pkg::CountW'(DEPTH);

   logic [oate_pkg::CountW-1:0] index_next;
   logic                        full_seen;
   logic                        empty_seen;
   logic                        middle_ok;

   assign index_next = oate_pkg::CountW'(rsp_found_index) + oate_pkg::CountW'(1);
   assign full_seen  = rsp_valid && (rsp_status == oate_pkg::ST_FULL);
   assign empty_seen = rsp_valid && (rsp_status == oate_pkg::ST_EMPTY);
   assign middle_ok  = (rsp_status == oate_pkg::ST_OK) && (index_next < rsp_count_now);

   `OATE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `OATE_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_count_now <= DepthCount)
   `OATE_ASSERT_NOW(a_full_count, clock, reset, full_seen, rsp_count_now == DepthCount)
   `OATE_ASSERT_NOW(a_empty_alone, clock, reset, empty_seen, rsp_last && rsp_count_now == '0)
   `OATE_ASSERT_NOW(a_dump_middle, clock, reset, rsp_valid && !rsp_last, middle_ok)

endmodule

bind ordered_array_table_engine_unit oate_checker #(
   .DEPTH(DEPTH)
) u_oate_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_index (rsp_chan.found_index),
   .rsp_count_now   (rsp_chan.count_now),
   .rsp_last        (rsp_chan.last)
);

/* dv/tb_ordered_array_table_engine_unit.sv */
// Self-checking testbench for the ordered array table engine with a scoreboard class.
`timescale 1ns / 1ps

module tb_ordered_array_table_engine_unit;

   localparam int TableDepth = 64;
   localparam int CycleLimit = 400000;

   // Op codes that the block takes and ignores.
   localparam logic [oate_pkg::OpW-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [oate_pkg::OpW-1:0] OP_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [oate_pkg::StatusW-1:0]       status;
      logic [oate_pkg::IndexW-1:0]        found_index;
      logic signed [oate_pkg::ValueW-1:0] entry_value;
      logic [oate_pkg::CountW-1:0]        count_now;
      logic                               last;
   } table_result_type;

   class table_scoreboard_type;
      logic signed [oate_pkg::ValueW-1:0] table_entries [TableDepth];
      int                                 table_count;
      table_result_type                   pending_results [$];
      int                                 error_count;

      function new();
         table_count = 0;
         error_count = 0;
      endfunction

      function void post(logic [oate_pkg::StatusW-1:0] status, int index,
                         logic signed [oate_pkg::ValueW-1:0] value, logic last_flag);
         table_result_type r;
         r.status      = status;
         r.found_index = index[oate_pkg::IndexW-1:0];
         r.entry_value = value;
         r.count_now   = table_count[oate_pkg::CountW-1:0];
         r.last        = last_flag;
         pending_results.push_back(r);
      endfunction

      // Applies one accepted item to the table copy and queues the results it causes.
      function void note_request(logic [oate_pkg::OpW-1:0] op,
                                 logic signed [oate_pkg::ValueW-1:0] value,
                                 logic [oate_pkg::PosW-1:0] position);
         int                                 pos;
         int                                 j;
         bit                                 hit;
         logic signed [oate_pkg::ValueW-1:0] key;
         pos = int'(position);
         case (op)
            oate_pkg::OP_CLEAR: begin
               table_count = 0;
               post(oate_pkg::ST_OK, 0, '0, 1'b1);
            end
            oate_pkg::OP_INSERT: begin
               // The position test takes precedence over the full test.
               if (pos > table_count) begin
                  post(oate_pkg::ST_BADPOS, 0, '0, 1'b1);
               end else if (table_count >= TableDepth) begin
                  post(oate_pkg::ST_FULL, 0, '0, 1'b1);
               end else begin
                  for (int i = table_count; i > pos; i--)
                     table_entries[i] = table_entries[i-1];
                  table_entries[pos] = value;
                  table_count++;
                  post(oate_pkg::ST_OK, 0, '0, 1'b1);
               end
            end
            oate_pkg::OP_DELETE: begin
               if (pos >= table_count) begin
                  post(oate_pkg::ST_BADPOS, 0, '0, 1'b1);
               end else begin
                  for (int i = pos; i + 1 < table_count; i++)
                     table_entries[i] = table_entries[i+1];
                  table_count--;
                  post(oate_pkg::ST_OK, 0, '0, 1'b1);
               end
            end
            oate_pkg::OP_SEARCH: begin
               hit = 1'b0;
               for (int i = 0; i < table_count; i++) begin
                  if (!hit && table_entries[i] == value) begin
                     post(oate_pkg::ST_OK, i, '0, 1'b1);
                     hit = 1'b1;
                  end
               end
               if (!hit) post(oate_pkg::ST_NOTFOUND, 0, '0, 1'b1);
            end
            oate_pkg::OP_SORT: begin
               for (int i = 1; i < table_count; i++) begin
                  key = table_entries[i];
                  j = i;
                  while (j > 0 && table_entries[j-1] > key) begin
                     table_entries[j] = table_entries[j-1];
                     j--;
                  end
                  table_entries[j] = key;
               end
               post(oate_pkg::ST_OK, 0, '0, 1'b1);
            end
            oate_pkg::OP_DUMP: begin
               if (table_count == 0) begin
                  post(oate_pkg::ST_EMPTY, 0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < table_count; i++)
                     post(oate_pkg::ST_OK, i, table_entries[i], i + 1 == table_count);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(table_result_type got);
         table_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result item: status %0d, count_now %0d", got.status,
                   got.count_now);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
         end
         if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
            error_count++;
         end
         if (got.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
            error_count++;
         end
         if (got.count_now !== want.count_now) begin
            $error("count_now: expected %0d, actual %0d", want.count_now, got.count_now);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   req_idle_pct;
   int   rsp_stall_pct;

   table_scoreboard_type sb = new();

   oate_req_if req_chan();
   oate_rsp_if rsp_chan();

   ordered_array_table_engine_unit #(
      .DEPTH (TableDepth)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: check each accepted item, then decide whether to stall the next cycle.
   initial begin
      table_result_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status      = rsp_chan.status;
            got.found_index = rsp_chan.found_index;
            got.entry_value = rsp_chan.entry_value;
            got.count_now   = rsp_chan.count_now;
            got.last        = rsp_chan.last;
            sb.check_response(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Called at a rising edge; returns after the item was accepted and any idle edges.
   task automatic send_item(logic [oate_pkg::OpW-1:0] op,
                            logic signed [oate_pkg::ValueW-1:0] value,
                            logic [oate_pkg::PosW-1:0] position);
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.item_value <= value;
      req_chan.position   <= position;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, value, position);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [oate_pkg::ValueW-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(6) - 3;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom();
      endcase
   endfunction

   task automatic random_item();
      int                                 r;
      int                                 cnt;
      logic [oate_pkg::OpW-1:0]           op;
      logic signed [oate_pkg::ValueW-1:0] value;
      logic [oate_pkg::PosW-1:0]          pos;
      r     = $urandom_range(99);
      cnt   = sb.table_count;
      value = pick_value();
      pos   = oate_pkg::PosW'($urandom_range(127));
      if (r < 35) begin
         op = oate_pkg::OP_INSERT;
         if ($urandom_range(9) != 0) pos = oate_pkg::PosW'($urandom_range(cnt));
      end else if (r < 52) begin
         op = oate_pkg::OP_DELETE;
         if (cnt > 0 && $urandom_range(9) != 0) pos = oate_pkg::PosW'($urandom_range(cnt - 1));
      end else if (r < 67) begin
         op = oate_pkg::OP_SEARCH;
         if (cnt > 0 && $urandom_range(1)) value = sb.table_entries[$urandom_range(cnt - 1)];
      end else if (r < 75) begin
         op = oate_pkg::OP_SORT;
      end else if (r < 92) begin
         op = oate_pkg::OP_DUMP;
      end else if (r < 96) begin
         op = oate_pkg::OP_CLEAR;
      end else begin
         op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      end
      send_item(op, value, pos);
   endtask

   // Fills the table to capacity, then works on the full table.
   task automatic fill_table();
      while (sb.table_count < TableDepth)
         send_item(oate_pkg::OP_INSERT, pick_value(),
                   oate_pkg::PosW'($urandom_range(sb.table_count)));
      send_item(oate_pkg::OP_INSERT, pick_value(),
                oate_pkg::PosW'($urandom_range(TableDepth - 1)));
      send_item(oate_pkg::OP_INSERT, pick_value(), oate_pkg::PosW'(TableDepth));
      send_item(oate_pkg::OP_INSERT, pick_value(), oate_pkg::PosW'(TableDepth + 1));
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_SEARCH, sb.table_entries[TableDepth - 1], '0);
      send_item(oate_pkg::OP_SORT, '0, '0);
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_DELETE, '0, oate_pkg::PosW'(TableDepth - 1));
      send_item(oate_pkg::OP_DELETE, '0, '0);
   endtask

   initial begin
      int phase_idle  [4] = '{0, 81, 0, 37};
      int phase_stall [4] = '{0, 0, 81, 37};
      cycle_count         = 0;
      req_idle_pct        = 0;
      rsp_stall_pct       = 0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= oate_pkg::OP_CLEAR;
      req_chan.item_value <= '0;
      req_chan.position   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table cases, both value extremes, bad positions, ignored ops.
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_SEARCH, '0, '0);
      send_item(oate_pkg::OP_DELETE, '0, 7'd0);
      send_item(oate_pkg::OP_INSERT, 32'sd9, 7'd1);
      send_item(oate_pkg::OP_INSERT, 32'sh7fffffff, 7'd0);
      send_item(oate_pkg::OP_INSERT, 32'sh80000000, 7'd0);
      send_item(oate_pkg::OP_INSERT, -32'sd1, 7'd2);
      send_item(oate_pkg::OP_INSERT, '0, 7'd1);
      send_item(oate_pkg::OP_INSERT, 32'sd5, 7'd127);
      send_item(oate_pkg::OP_SEARCH, -32'sd1, '0);
      send_item(oate_pkg::OP_SEARCH, 32'sd12345, '0);
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_SORT, '0, '0);
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_DELETE, '0, 7'd64);
      send_item(oate_pkg::OP_DELETE, '0, 7'd4);
      send_item(oate_pkg::OP_DELETE, '0, 7'd1);
      send_item(OP_UNUSED_A, $urandom(), oate_pkg::PosW'($urandom_range(127)));
      send_item(OP_UNUSED_B, $urandom(), oate_pkg::PosW'($urandom_range(127)));
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_CLEAR, '0, '0);
      send_item(oate_pkg::OP_DUMP, '0, '0);
      send_item(oate_pkg::OP_SORT, '0, '0);

      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         repeat (10) random_item();
         if (p == 3) fill_table();
      end

      req_chan.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      // Ignored items and stray results may still be in flight.
      repeat (2 * TableDepth + 16) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
